// ===== rtl/cpualu_pkg.sv =====
package cpualu_pkg;

  // Operation codes; code 15 is unused and passes operand_a and the flags through.
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_ADC   = 4'd1,
    OP_SUB   = 4'd2,
    OP_SBC   = 4'd3,
    OP_AND   = 4'd4,
    OP_XOR   = 4'd5,
    OP_OR    = 4'd6,
    OP_CP    = 4'd7,
    OP_INC8  = 4'd8,
    OP_DEC8  = 4'd9,
    OP_DAA   = 4'd10,
    OP_CPL   = 4'd11,
    OP_ADD16 = 4'd12,
    OP_INC16 = 4'd13,
    OP_DEC16 = 4'd14
  } mode_t;

  localparam logic [3:0] NIB_MAX    = 4'hF;
  localparam logic [3:0] BCD_MAX    = 4'd9;
  localparam logic [7:0] BCD_BYTE   = 8'h99;
  localparam logic [3:0] DAA_DIGIT  = 4'h6;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        zero_in;
    logic        sub_in;
    logic        half_in;
    logic        carry_in;
  } in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic        zero_out;
    logic        sub_out;
    logic        half_out;
    logic        carry_out;
  } out_t;

endpackage

// ===== rtl/cpualu_core.sv =====
module cpualu_core (
  input  cpualu_pkg::in_t  op,
  output cpualu_pkg::out_t res
);
  import cpualu_pkg::*;

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin;
  logic [4:0]  add_lo;
  logic [8:0]  add_full;
  logic [4:0]  sub_lo;
  logic [8:0]  sub_full;
  logic [7:0]  logic_r;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_ofs;
  logic [7:0]  daa_r;
  logic [12:0] add16_lo;
  logic [16:0] add16_full;

  assign a8  = op.operand_a[7:0];
  assign b8  = op.operand_b[7:0];
  assign cin = ((op.mode == OP_ADC) || (op.mode == OP_SBC)) ? op.carry_in : 1'b0;

  assign add_lo   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, cin};
  assign add_full = {1'b0, a8} + {1'b0, b8} + {8'b0, cin};
  // borrow shows up in the top bit of the widened difference
  assign sub_lo   = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'b0, cin};
  assign sub_full = {1'b0, a8} - {1'b0, b8} - {8'b0, cin};

  always_comb begin
    unique case (op.mode)
      OP_AND:  logic_r = a8 & b8;
      OP_XOR:  logic_r = a8 ^ b8;
      default: logic_r = a8 | b8;
    endcase
  end

  // decimal adjust: after add, correct on flag or out-of-range digit;
  // after subtract, correct on flag only
  assign daa_hi  = op.sub_in ? op.carry_in : (op.carry_in || (a8 > BCD_BYTE));
  assign daa_lo  = op.sub_in ? op.half_in  : (op.half_in  || (a8[3:0] > BCD_MAX));
  assign daa_ofs = {(daa_hi ? DAA_DIGIT : 4'h0), (daa_lo ? DAA_DIGIT : 4'h0)};
  assign daa_r   = op.sub_in ? (a8 - daa_ofs) : (a8 + daa_ofs);

  assign add16_lo   = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
  assign add16_full = {1'b0, op.operand_a} + {1'b0, op.operand_b};

  always_comb begin
    res.result_value = op.operand_a;
    res.zero_out     = op.zero_in;
    res.sub_out      = op.sub_in;
    res.half_out     = op.half_in;
    res.carry_out    = op.carry_in;
    unique case (op.mode)
      OP_ADD, OP_ADC: begin
        res.result_value = {8'h00, add_full[7:0]};
        res.zero_out     = (add_full[7:0] == 8'h00);
        res.sub_out      = 1'b0;
        res.half_out     = add_lo[4];
        res.carry_out    = add_full[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        res.result_value = (op.mode == OP_CP) ? op.operand_a : {8'h00, sub_full[7:0]};
        res.zero_out     = (sub_full[7:0] == 8'h00);
        res.sub_out      = 1'b1;
        res.half_out     = sub_lo[4];
        res.carry_out    = sub_full[8];
      end
      OP_AND, OP_XOR, OP_OR: begin
        res.result_value = {8'h00, logic_r};
        res.zero_out     = (logic_r == 8'h00);
        res.sub_out      = 1'b0;
        res.half_out     = (op.mode == OP_AND);
        res.carry_out    = 1'b0;
      end
      OP_INC8: begin
        res.result_value = {8'h00, a8 + 8'd1};
        res.zero_out     = (a8 == 8'hFF);
        res.sub_out      = 1'b0;
        res.half_out     = (a8[3:0] == NIB_MAX);
      end
      OP_DEC8: begin
        res.result_value = {8'h00, a8 - 8'd1};
        res.zero_out     = (a8 == 8'h01);
        res.sub_out      = 1'b1;
        res.half_out     = (a8[3:0] == 4'h0);
      end
      OP_DAA: begin
        res.result_value = {8'h00, daa_r};
        res.zero_out     = (daa_r == 8'h00);
        res.half_out     = 1'b0;
        res.carry_out    = op.sub_in ? op.carry_in : daa_hi;
      end
      OP_CPL: begin
        res.result_value = {8'h00, ~a8};
        res.sub_out      = 1'b1;
        res.half_out     = 1'b1;
      end
      OP_ADD16: begin
        res.result_value = add16_full[15:0];
        res.sub_out      = 1'b0;
        res.half_out     = add16_lo[12];
        res.carry_out    = add16_full[16];
      end
      OP_INC16: res.result_value = op.operand_a + 16'd1;
      OP_DEC16: res.result_value = op.operand_a - 16'd1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/cpu_alu_with_flags.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_data  (mode, operands, flags in)
// out     | output    | out_valid/out_stall | out_data (result, flags out)
//
// Two register stages: an input register and a result register with the
// whole ALU between them. A taken transaction enters the input register and
// moves on to the result register when that stage is free; one transaction
// per cycle is sustained while out_stall stays low.
// rst (synchronous) empties both stages. While out_stall holds a result,
// the input register still takes one more transaction before in_stall rises.
module cpu_alu_with_flags (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpualu_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cpualu_pkg::out_t out_data
);
  import cpualu_pkg::*;

  // input register
  logic s1_valid;
  in_t  s1_data;
  // combinational ALU result of the input register
  out_t alu_res;
  // control
  logic out_free;
  logic s1_take;

  // result stage can load when empty or its transaction leaves now
  assign out_free = !out_valid || !out_stall;
  // input stage can load when empty or its contents move on
  assign s1_take  = !s1_valid || out_free;
  assign in_stall = !s1_take;

  cpualu_core u_core (
    .op  (s1_data),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= alu_res;
    end
  end

  // in_stall only when both stages are full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("in_stall raised with room in the pipeline");

  // an accepted transaction lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction lost");

  // a moving input stage produces the matching result
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |=> (out_valid && (out_data == $past(alu_res))))
    else $error("result stage did not capture the ALU output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule
